### sv/kms_pkg.sv
// Shared types, constants and key table for the keypad matrix scanner.
package kms_pkg;

  localparam int COUNT_W = 8;
  localparam int HOLD_W  = 8;
  localparam int KEYS    = 16;
  localparam int KEY_W   = 4;
  localparam int CODE_W  = 6;
  localparam int FIFO_DEPTH = 2;

  localparam logic EV_PRESS   = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

  localparam logic [HOLD_W-1:0] HOLD_RST = 8'd3;

  typedef struct packed {
    logic            kind;
    logic [KEYS-1:0] mask;
  } job_t;

  typedef struct packed {
    logic              shift;
    logic [CODE_W-1:0] code;
  } key_entry_t;

  // index is row*4+col
  function automatic key_entry_t key_lookup(input logic [KEY_W-1:0] idx);
    key_entry_t e;
    case (idx)
      4'd0:    e = '{1'b0, 6'd2};
      4'd1:    e = '{1'b0, 6'd3};
      4'd2:    e = '{1'b0, 6'd4};
      4'd3:    e = '{1'b1, 6'd30};
      4'd4:    e = '{1'b0, 6'd5};
      4'd5:    e = '{1'b0, 6'd6};
      4'd6:    e = '{1'b0, 6'd7};
      4'd7:    e = '{1'b1, 6'd48};
      4'd8:    e = '{1'b0, 6'd8};
      4'd9:    e = '{1'b0, 6'd9};
      4'd10:   e = '{1'b0, 6'd10};
      4'd11:   e = '{1'b1, 6'd46};
      4'd12:   e = '{1'b1, 6'd9};
      4'd13:   e = '{1'b0, 6'd11};
      4'd14:   e = '{1'b1, 6'd4};
      4'd15:   e = '{1'b1, 6'd32};
      default: e = '{1'b0, 6'd0};
    endcase
    return e;
  endfunction

  // scan position {col,row} <-> sample bit {row,col}
  function automatic logic [KEY_W-1:0] pos_to_idx(input logic [KEY_W-1:0] pos);
    return {pos[1:0], pos[3:2]};
  endfunction

  function automatic logic [KEYS-1:0] to_scan_order(input logic [KEYS-1:0] sample);
    logic [KEYS-1:0] m;
    for (int p = 0; p < KEYS; p++) begin
      m[p] = sample[pos_to_idx(KEY_W'(p))];
    end
    return m;
  endfunction

  function automatic logic [KEY_W-1:0] lowest_set(input logic [KEYS-1:0] m);
    logic [KEY_W-1:0] r;
    r = '0;
    for (int i = KEYS - 1; i >= 0; i--) begin
      if (m[i]) r = KEY_W'(i);
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] highest_set(input logic [KEYS-1:0] m);
    logic [KEY_W-1:0] r;
    r = '0;
    for (int i = 0; i < KEYS; i++) begin
      if (m[i]) r = KEY_W'(i);
    end
    return r;
  endfunction

endpackage

### sv/kms_front.sv
// Front end: accepts samples, tracks the held key and debounce count, issues event jobs.
module kms_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [kms_pkg::HOLD_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kms_pkg::KEYS-1:0]   in_matrix_sample,
  input  logic                       q_full,
  output logic                       q_push,
  output kms_pkg::job_t              q_data
);
  import kms_pkg::*;

  logic [HOLD_W-1:0]  hold_time_r;
  logic [COUNT_W-1:0] hold_count_r, hold_count_nxt;
  logic [KEY_W-1:0]   held_pos_r, held_pos_nxt;
  logic [KEYS-1:0]    scan;
  logic [COUNT_W-1:0] load;
  logic               accept;
  logic               pressed;
  job_t               job;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign load     = hold_time_r[COUNT_W-1:0];
  assign scan     = to_scan_order(in_matrix_sample);
  assign pressed  = in_matrix_sample[pos_to_idx(held_pos_r)];

  always_comb begin
    hold_count_nxt = hold_count_r;
    held_pos_nxt   = held_pos_r;
    job.kind       = EV_PRESS;
    job.mask       = '0;
    if (hold_count_r == '0) begin
      job.mask = scan;
      if (|scan) begin
        hold_count_nxt = load;
        held_pos_nxt   = highest_set(scan);
      end
    end else begin
      hold_count_nxt = pressed ? load : hold_count_r - COUNT_W'(1);
      job.kind       = EV_RELEASE;
      if (hold_count_nxt == '0) job.mask = KEYS'(1) << held_pos_r;
    end
  end

  assign q_push = accept && (|job.mask);
  assign q_data = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r  <= HOLD_RST;
      hold_count_r <= '0;
      held_pos_r   <= '0;
    end else begin
      if (cfg_we) hold_time_r <= cfg_wdata;
      if (accept) begin
        hold_count_r <= hold_count_nxt;
        held_pos_r   <= held_pos_nxt;
      end
    end
  end

endmodule

### sv/kms_fifo.sv
// Two-entry job queue between the front end and the event emitter.
module kms_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kms_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output kms_pkg::job_t pop_data,
  output logic          empty
);
  import kms_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  job_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == (PTR_W + 1)'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### sv/kms_back.sv
// Back end: walks each job's key mask in scan order and emits one event beat per key.
module kms_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  kms_pkg::job_t                q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_event_kind,
  output logic [kms_pkg::CODE_W-1:0]   out_key_code,
  output logic                         out_shift_flag,
  output logic                         out_last
);
  import kms_pkg::*;

  logic              busy_r;
  logic              kind_r;
  logic [KEYS-1:0]   mask_r;
  logic              out_valid_r;
  logic              kind_out_r;
  logic [CODE_W-1:0] code_r;
  logic              shift_r;
  logic              last_r;
  logic              take;
  logic [KEY_W-1:0]  pos;
  logic [KEYS-1:0]   rest;
  key_entry_t        entry;

  assign take  = busy_r && (!out_valid_r || !out_stall);
  assign pos   = lowest_set(mask_r);
  assign rest  = mask_r & ~(KEYS'(1) << pos);
  assign entry = key_lookup(pos_to_idx(pos));
  assign q_pop = !busy_r && !q_empty;

  always_ff @(posedge clk) begin
    if (take) begin
      kind_out_r <= kind_r;
      code_r     <= entry.code;
      shift_r    <= entry.shift;
      last_r     <= (rest == '0);
    end
    if (q_pop) begin
      kind_r <= q_data.kind;
      mask_r <= q_data.mask;
    end else if (take) begin
      mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop)     busy_r <= 1'b1;
      else if (take) busy_r <= (rest != '0);
      if (take)      out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_out_r;
  assign out_key_code   = code_r;
  assign out_shift_flag = shift_r;
  assign out_last       = last_r;

endmodule

### sv/keypad_matrix_scanner.sv
// Top level of the 4x4 keypad matrix scanner with release debounce.
//
// Input channel (in_valid / in_stall / in_matrix_sample): one beat per poll
// tick, bit row*4+col set when that key reads pressed.
// Output channel (out_valid / out_stall / out_*): one beat per key event;
// out_last marks the final beat caused by a tick. Quiet ticks give no beats.
// Config: cfg_we writes cfg_wdata into the hold time (3 after reset).
// The front end classifies a tick in the cycle it is accepted and updates the
// held key and debounce count at once; it stalls only when the two-entry job
// queue is full. The back end loads one job per cycle when idle, then emits
// one event per cycle unless out_stall holds the output register. A tick's job
// passes through the queue, the back end's job register and the output register.
// When out_stall is high the output register holds its beat and the back end
// waits; the queue absorbs up to two more ticks with events before in_stall rises.
// Reset (rst_n low, synchronous) empties the queue, drops any pending beats
// and clears the held key and debounce count.
module keypad_matrix_scanner (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [kms_pkg::HOLD_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kms_pkg::KEYS-1:0]   in_matrix_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_event_kind,
  output logic [kms_pkg::CODE_W-1:0] out_key_code,
  output logic                       out_shift_flag,
  output logic                       out_last
);
  import kms_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_in, q_out;

  kms_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_matrix_sample (in_matrix_sample),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  kms_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  kms_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_key_code   (out_key_code),
    .out_shift_flag (out_shift_flag),
    .out_last       (out_last)
  );

endmodule
